### hw/rtl/npa_pkg.sv
// Shared constants, command and status codes, and types of the node pool allocator.
`timescale 1ns / 1ps
`default_nettype none

package npa_pkg;

	// Pool geometry.
	localparam int unsigned POOL_DEPTH = 1024;
	localparam int unsigned IDX_W      = $clog2(POOL_DEPTH);
	localparam int unsigned CNT_W      = IDX_W + 1;
	localparam int unsigned CUR_W      = CNT_W + 1;

	// Command codes.
	localparam logic [1:0] CMD_ALLOC_ONE = 2'd0;
	localparam logic [1:0] CMD_ALLOC_RUN = 2'd1;
	localparam logic [1:0] CMD_FREE_RUN  = 2'd2;
	localparam logic [1:0] CMD_CLEAR     = 2'd3;

	// Status codes.
	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_EXHAUSTED = 2'd1;
	localparam logic [1:0] STS_ZERO      = 2'd2;
	localparam logic [1:0] STS_OVERFLOW  = 2'd3;

	// Values after reset.
	localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(POOL_DEPTH);

	// One result item.
	typedef struct packed {
		logic [IDX_W-1:0] granted_index;
		logic [1:0]       status;
		logic [CNT_W-1:0] live_count;
	} npa_result_t;

endpackage

`default_nettype wire

### hw/rtl/node_pool_allocator_unit.sv
// Top level of the node pool allocator: free stack memory, bump pointer and command sequencer.
`timescale 1ns / 1ps
`default_nettype none

// The node pool allocator hands out slot indexes from a pool of POOL_DEPTH slots.
// Each input transaction carries one command and yields exactly one result transaction.
// A single allocation served from the free stack passes through the ST_POP state, because the
// stack lives in a synchronous memory whose read data arrives in the cycle after the address.
// A single allocation from the bump pointer, a multi-slot run allocation, a zero-length
// command and a clear finish straight from ST_IDLE. A run free walks the run in ST_FREE and
// pushes at most one index per cycle through the single write port of the stack memory. The
// result lands in an output register, so the next command is taken while the previous result
// waits; a command only stalls when it finishes while an earlier result is still not taken.
// The stack memory needs no clearing pass: only entries below the stack depth are ever read.
// Write pool_limit via the configuration channel only while idle; the block does not check.
module node_pool_allocator_unit (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	// Command channel.
	input  wire logic                      in_valid,
	output logic                           in_ready,
	input  wire logic [1:0]                cmd,
	input  wire logic [npa_pkg::CNT_W-1:0] count,
	input  wire logic [npa_pkg::IDX_W-1:0] slot_index,
	// Result channel.
	output logic                           out_valid,
	input  wire logic                      out_ready,
	output logic [npa_pkg::IDX_W-1:0]      granted_index,
	output logic [1:0]                     status,
	output logic [npa_pkg::CNT_W-1:0]      live_count,
	// Configuration channel.
	input  wire logic                      cfg_valid,
	output logic                           cfg_ready,
	input  wire logic [npa_pkg::CNT_W-1:0] cfg_data
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_POP,
		ST_FREE,
		ST_HOLD
	} state_t;

	localparam logic [npa_pkg::CNT_W-1:0] DEPTH_C = npa_pkg::CNT_W'(npa_pkg::POOL_DEPTH);
	localparam logic [npa_pkg::CNT_W-1:0] ONE_C   = npa_pkg::CNT_W'(1);

	// Registers.
	state_t                      state_q, state_d;
	logic [npa_pkg::CNT_W-1:0]   pool_limit_q;
	logic [npa_pkg::CNT_W-1:0]   depth_q, depth_d;
	logic [npa_pkg::CNT_W-1:0]   bump_q, bump_d;
	logic [npa_pkg::CNT_W-1:0]   active_q, active_d;
	logic [npa_pkg::CUR_W-1:0]   cursor_q, cursor_d;
	logic [npa_pkg::CNT_W-1:0]   remain_q, remain_d;
	logic                        dropped_q, dropped_d;
	logic                        out_valid_q, out_valid_d;
	npa_pkg::npa_result_t        out_q, out_d;
	npa_pkg::npa_result_t        hold_q, hold_d;

	// Free stack memory ports.
	logic [npa_pkg::IDX_W-1:0]   stack_mem [npa_pkg::POOL_DEPTH];
	logic                        mem_we, mem_re;
	logic [npa_pkg::IDX_W-1:0]   mem_waddr, mem_wdata, mem_raddr;
	logic [npa_pkg::IDX_W-1:0]   mem_rdata_q;

	// Finished result of this cycle.
	logic                        fin_en;
	npa_pkg::npa_result_t        fin_res;

	logic [npa_pkg::CNT_W-1:0]   eff_limit;
	logic                        out_free;
	logic                        in_fire;

	assign eff_limit = (pool_limit_q > DEPTH_C) ? DEPTH_C : pool_limit_q;
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	assign out_valid     = out_valid_q;
	assign granted_index = out_q.granted_index;
	assign status        = out_q.status;
	assign live_count    = out_q.live_count;

	// Command sequencer and next-state logic.
	always_comb begin
		logic [npa_pkg::CUR_W-1:0] bump_sum;
		logic [npa_pkg::CUR_W-1:0] live_sum;
		logic                      single;
		logic                      in_pool;
		logic                      drop_now;

		state_d     = state_q;
		depth_d     = depth_q;
		bump_d      = bump_q;
		active_d    = active_q;
		cursor_d    = cursor_q;
		remain_d    = remain_q;
		dropped_d   = dropped_q;
		hold_d      = hold_q;
		out_d       = out_q;
		out_valid_d = out_valid_q && !out_ready;
		mem_we      = 1'b0;
		mem_re      = 1'b0;
		mem_waddr   = depth_q[npa_pkg::IDX_W-1:0];
		mem_wdata   = cursor_q[npa_pkg::IDX_W-1:0];
		mem_raddr   = npa_pkg::IDX_W'(depth_q - ONE_C);
		fin_en      = 1'b0;
		fin_res     = '0;
		drop_now    = 1'b0;

		single   = (cmd == npa_pkg::CMD_ALLOC_ONE)
			|| ((cmd == npa_pkg::CMD_ALLOC_RUN) && (count == ONE_C));
		bump_sum = {1'b0, bump_q} + {1'b0, count};
		live_sum = {1'b0, active_q} + {1'b0, count};
		in_pool  = (cursor_q < {1'b0, bump_q});

		unique case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					if (single) begin
						if (depth_q != '0) begin
							// Pop: read the top entry, data returns next cycle.
							mem_re  = 1'b1;
							depth_d = depth_q - ONE_C;
							state_d = ST_POP;
						end else if (bump_q < eff_limit) begin
							bump_d                = bump_q + ONE_C;
							active_d              = (active_q == '1) ? active_q
								: active_q + ONE_C;
							fin_en                = 1'b1;
							fin_res.granted_index = bump_q[npa_pkg::IDX_W-1:0];
							fin_res.status        = npa_pkg::STS_OK;
						end else begin
							fin_en         = 1'b1;
							fin_res.status = npa_pkg::STS_EXHAUSTED;
						end
					end else begin
						unique case (cmd)
							npa_pkg::CMD_ALLOC_RUN: begin
								fin_en = 1'b1;
								if (count == '0) begin
									fin_res.status = npa_pkg::STS_ZERO;
								end else if (bump_sum > {1'b0, eff_limit}) begin
									fin_res.status = npa_pkg::STS_EXHAUSTED;
								end else begin
									bump_d                = bump_sum[npa_pkg::CNT_W-1:0];
									active_d              = live_sum[npa_pkg::CNT_W] ? '1
										: live_sum[npa_pkg::CNT_W-1:0];
									fin_res.granted_index = bump_q[npa_pkg::IDX_W-1:0];
									fin_res.status        = npa_pkg::STS_OK;
								end
							end
							npa_pkg::CMD_FREE_RUN: begin
								if (count == '0) begin
									fin_en         = 1'b1;
									fin_res.status = npa_pkg::STS_ZERO;
								end else begin
									cursor_d  = npa_pkg::CUR_W'(slot_index);
									remain_d  = count;
									dropped_d = 1'b0;
									state_d   = ST_FREE;
								end
							end
							npa_pkg::CMD_CLEAR: begin
								depth_d        = '0;
								bump_d         = '0;
								active_d       = '0;
								fin_en         = 1'b1;
								fin_res.status = npa_pkg::STS_OK;
							end
							default: begin
								// Single allocations are handled above.
								fin_en         = 1'b1;
								fin_res.status = npa_pkg::STS_OK;
							end
						endcase
					end
					fin_res.live_count = active_d;
				end
			end
			ST_POP: begin
				active_d              = (active_q == '1) ? active_q : active_q + ONE_C;
				fin_en                = 1'b1;
				fin_res.granted_index = mem_rdata_q;
				fin_res.status        = npa_pkg::STS_OK;
				fin_res.live_count    = active_d;
			end
			ST_FREE: begin
				// One run index per cycle; indexes outside the bump region are skipped.
				if (in_pool) begin
					if (depth_q < DEPTH_C) begin
						mem_we  = 1'b1;
						depth_d = depth_q + ONE_C;
					end else begin
						drop_now = 1'b1;
					end
					active_d = (active_q == '0) ? active_q : active_q - ONE_C;
				end
				dropped_d = dropped_q || drop_now;
				cursor_d  = cursor_q + npa_pkg::CUR_W'(1);
				remain_d  = remain_q - ONE_C;
				if (remain_q == ONE_C) begin
					fin_en             = 1'b1;
					fin_res.status     = dropped_d ? npa_pkg::STS_OVERFLOW : npa_pkg::STS_OK;
					fin_res.live_count = active_d;
				end
			end
			ST_HOLD: begin
				if (out_free) begin
					out_d       = hold_q;
					out_valid_d = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// Deliver a finished result to the output register, or park it.
		if (fin_en) begin
			if (out_free) begin
				out_d       = fin_res;
				out_valid_d = 1'b1;
				state_d     = ST_IDLE;
			end else begin
				hold_d  = fin_res;
				state_d = ST_HOLD;
			end
		end
	end

	// Control state and registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			pool_limit_q <= npa_pkg::LIMIT_RESET;
			depth_q      <= '0;
			bump_q       <= '0;
			active_q     <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q     <= state_d;
			depth_q     <= depth_d;
			bump_q      <= bump_d;
			active_q    <= active_d;
			out_valid_q <= out_valid_d;
			if (cfg_valid && cfg_ready) begin
				pool_limit_q <= cfg_data;
			end
		end
	end

	// Payload registers need no reset.
	always_ff @(posedge clk) begin
		cursor_q  <= cursor_d;
		remain_q  <= remain_d;
		dropped_q <= dropped_d;
		out_q     <= out_d;
		hold_q    <= hold_d;
	end

	// Free stack memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			stack_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			mem_rdata_q <= stack_mem[mem_raddr];
		end
	end

endmodule

`default_nettype wire

### hw/rtl/npa_checker.sv
// Port-level assertions for the node pool allocator and the bind that attaches them.
`timescale 1ns / 1ps
`default_nettype none

module npa_checker (
	input wire logic                      clk,
	input wire logic                      arst_n,
	input wire logic                      in_valid,
	input wire logic                      in_ready,
	input wire logic [1:0]                cmd,
	input wire logic [npa_pkg::CNT_W-1:0] count,
	input wire logic                      out_valid,
	input wire logic                      out_ready,
	input wire logic [npa_pkg::IDX_W-1:0] granted_index,
	input wire logic [1:0]                status,
	input wire logic [npa_pkg::CNT_W-1:0] live_count
);

	logic in_fire;
	logic out_free;

	assign in_fire  = in_valid && in_ready;
	assign out_free = !out_valid || out_ready;

	// A stalled result transaction keeps its payload.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(granted_index)
			&& $stable(status) && $stable(live_count))
		else $error("result changed while stalled");

	// A failed command never reports a slot.
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == npa_pkg::STS_EXHAUSTED || status == npa_pkg::STS_ZERO)
			|-> granted_index == '0)
		else $error("failed command reported a nonzero slot");

	// A clear with a free output slot reports an empty pool in the next cycle.
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == npa_pkg::CMD_CLEAR && out_free
			|=> out_valid && live_count == '0 && status == npa_pkg::STS_OK)
		else $error("clear did not report an empty pool");

	// A zero-length run allocation with a free output reports the zero count status.
	a_zero_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == npa_pkg::CMD_ALLOC_RUN && count == '0 && out_free
			|=> out_valid && status == npa_pkg::STS_ZERO)
		else $error("zero-length run not reported");

	// A run free with a nonzero count makes the block busy, so in_ready drops once it is taken.
	a_free_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && cmd == npa_pkg::CMD_FREE_RUN && count != '0 |=> !in_ready)
		else $error("command taken during a run free");

endmodule

bind node_pool_allocator_unit npa_checker u_npa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.cmd           (cmd),
	.count         (count),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.granted_index (granted_index),
	.status        (status),
	.live_count    (live_count)
);

`default_nettype wire

### verif/node_pool_allocator_unit_tb.sv
// Self-checking testbench of the node pool allocator: a directed table, then random commands.
`timescale 1ns / 1ps

module node_pool_allocator_unit_tb;

	import npa_pkg::*;

	localparam int unsigned CLK_HALF    = 6;
	localparam int unsigned CYCLE_LIMIT = 4_000_000;
	localparam int unsigned PHASE_ITEMS = 200;
	localparam int unsigned LONG_HOLD   = 400;
	localparam int unsigned LIVE_MAX    = (1 << CNT_W) - 1;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	// One row of the directed table: a limit write or a command with an optional fixed answer.
	typedef struct {
		bit          is_cfg;
		cnt_t        limit;
		logic [1:0]  op;
		cnt_t        n;
		idx_t        first;
		bit          typed;
		npa_result_t want;
	} plan_row_t;

	logic       clk           = 1'b0;
	logic       arst_n        = 1'b0;
	logic       in_valid      = 1'b0;
	logic       in_ready;
	logic [1:0] cmd           = CMD_ALLOC_ONE;
	cnt_t       count         = '0;
	idx_t       slot_index    = '0;
	logic       out_valid;
	logic       out_ready     = 1'b0;
	idx_t       granted_index;
	logic [1:0] status;
	cnt_t       live_count;
	logic       cfg_valid     = 1'b0;
	logic       cfg_ready;
	cnt_t       cfg_data      = '0;

	// Shadow copy of the pool state and of the limit register.
	idx_t        shadow_stack [POOL_DEPTH];
	int unsigned shadow_depth = 0;
	int unsigned shadow_bump  = 0;
	int unsigned shadow_live  = 0;
	int unsigned shadow_limit = LIMIT_RESET;

	npa_result_t grant_queue [$];
	plan_row_t   plan [$];
	int unsigned mismatches    = 0;
	int unsigned cycle_count   = 0;
	int unsigned send_idle_pct = 15;
	int unsigned recv_idle_pct = 75;
	int unsigned hold_asked    = 0;
	int unsigned hold_taken    = 0;
	int unsigned hold_left     = 0;

	node_pool_allocator_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.cmd           (cmd),
		.count         (count),
		.slot_index    (slot_index),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.granted_index (granted_index),
		.status        (status),
		.live_count    (live_count),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	always #CLK_HALF clk = ~clk;

	// The live count saturates at its top value.
	function automatic void add_live(input int unsigned n);
		shadow_live = (shadow_live + n > LIVE_MAX) ? LIVE_MAX : shadow_live + n;
	endfunction

	// Single slot: the most recently freed slot first, else the bump pointer.
	function automatic logic [1:0] take_single(output idx_t slot, input int unsigned cap);
		slot = '0;
		if (shadow_depth > 0) begin
			shadow_depth--;
			slot = shadow_stack[shadow_depth];
			add_live(1);
			return STS_OK;
		end
		if (shadow_bump >= cap)
			return STS_EXHAUSTED;
		slot = idx_t'(shadow_bump);
		shadow_bump++;
		add_live(1);
		return STS_OK;
	endfunction

	// Works out the result of one command and advances the shadow state.
	function automatic npa_result_t predict_grant(input logic [1:0] op, input cnt_t n,
			input idx_t first);
		npa_result_t res;
		int unsigned cap;
		int unsigned s;
		bit          dropped;
		idx_t        slot;
		logic [1:0]  st;
		cap = (shadow_limit > POOL_DEPTH) ? POOL_DEPTH : shadow_limit;
		slot = '0;
		st = STS_OK;
		dropped = 1'b0;
		case (op)
			CMD_ALLOC_ONE: st = take_single(slot, cap);
			CMD_ALLOC_RUN: begin
				if (n == 0)
					st = STS_ZERO;
				else if (n == 1)
					st = take_single(slot, cap);
				else if (shadow_bump + n > cap)
					st = STS_EXHAUSTED;
				else begin
					slot = idx_t'(shadow_bump);
					shadow_bump += n;
					add_live(n);
				end
			end
			CMD_FREE_RUN: begin
				if (n == 0)
					st = STS_ZERO;
				// Slots at or past the bump pointer, or past the last slot, are skipped.
				for (s = first; s < first + n; s++) begin
					if (s < shadow_bump && s < POOL_DEPTH) begin
						if (shadow_depth < POOL_DEPTH) begin
							shadow_stack[shadow_depth] = idx_t'(s);
							shadow_depth++;
						end else
							dropped = 1'b1;
						if (shadow_live > 0)
							shadow_live--;
					end
				end
				if (dropped)
					st = STS_OVERFLOW;
			end
			default: begin
				shadow_depth = 0;
				shadow_bump = 0;
				shadow_live = 0;
			end
		endcase
		if (st != STS_OK)
			slot = '0;
		res.granted_index = slot;
		res.status = st;
		res.live_count = cnt_t'(shadow_live);
		return res;
	endfunction

	function automatic void plan_cmd(input logic [1:0] op, input cnt_t n, input idx_t first,
			input bit typed, input idx_t idx, input logic [1:0] st, input cnt_t live);
		plan_row_t row;
		row.is_cfg = 1'b0;
		row.limit = '0;
		row.op = op;
		row.n = n;
		row.first = first;
		row.typed = typed;
		row.want.granted_index = idx;
		row.want.status = st;
		row.want.live_count = live;
		plan = {plan, row};
	endfunction

	function automatic void plan_cfg(input cnt_t value);
		plan_row_t row;
		row.is_cfg = 1'b1;
		row.limit = value;
		row.op = CMD_ALLOC_ONE;
		row.n = '0;
		row.first = '0;
		row.typed = 1'b0;
		row.want = '0;
		plan = {plan, row};
	endfunction

	// Offers one command transaction and records its expected result once it is taken.
	task automatic issue_cmd(input logic [1:0] op, input cnt_t n, input idx_t first,
			input bit typed, input npa_result_t want);
		npa_result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		count <= n;
		slot_index <= first;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pred = predict_grant(op, n, first);
		grant_queue = {grant_queue, (typed ? want : pred)};
	endtask

	// Mostly well-formed traffic: frees aim at slots handed out, with some noise mixed in.
	task automatic issue_random_cmd();
		int unsigned pick;
		logic [1:0]  op;
		cnt_t        n;
		idx_t        first;
		pick = $urandom_range(99);
		n = cnt_t'($urandom_range(2, 12));
		first = idx_t'($urandom);
		if (pick < 40)
			op = CMD_ALLOC_ONE;
		else if (pick < 62) begin
			op = CMD_ALLOC_RUN;
			if (pick < 44)
				n = cnt_t'($urandom_range(0, 1));
			else if (pick < 46)
				n = cnt_t'($urandom);
		end else if (pick < 95) begin
			op = CMD_FREE_RUN;
			if (shadow_bump > 0 && pick < 88)
				first = idx_t'($urandom_range(0, shadow_bump - 1));
			if (pick < 66)
				n = cnt_t'($urandom_range(0, 1));
			else if (pick == 94)
				n = cnt_t'($urandom);
		end else
			op = CMD_CLEAR;
		issue_cmd(op, n, first, 1'b0, '0);
	endtask

	// Stops offering commands until every outstanding result has been taken.
	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (grant_queue.size() != 0)
			@(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// The limit is only written while the block is idle.
	task automatic write_limit(input cnt_t value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		shadow_limit = value;
	endtask

	// Compares one result transaction with the oldest expectation.
	function automatic void check_grant();
		npa_result_t want;
		if (grant_queue.size() == 0) begin
			$display("%0t: result with none expected: index %0d status %0d live %0d",
				$time, granted_index, status, live_count);
			mismatches++;
			return;
		end
		want = grant_queue.pop_front();
		if (granted_index !== want.granted_index) begin
			$display("%0t: granted_index expected %0d actual %0d",
				$time, want.granted_index, granted_index);
			mismatches++;
		end
		if (status !== want.status) begin
			$display("%0t: status expected %0d actual %0d", $time, want.status, status);
			mismatches++;
		end
		if (live_count !== want.live_count) begin
			$display("%0t: live_count expected %0d actual %0d",
				$time, want.live_count, live_count);
			mismatches++;
		end
	endfunction

	// Result side: checks each transaction and stalls at random or for one long stretch.
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				check_grant();
			if (hold_left > 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (hold_asked != hold_taken) begin
				hold_taken <= hold_asked;
				hold_left <= LONG_HOLD;
				out_ready <= 1'b0;
			end else
				out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Guard against a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned k;

		// Directed table: edges of every field, each command and the corner cases of the pool.
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 0, STS_OK, 1);
		plan_cmd(CMD_ALLOC_RUN, 0, 1023, 1, 0, STS_ZERO, 1);
		plan_cmd(CMD_FREE_RUN, 0, 1023, 1, 0, STS_ZERO, 1);
		plan_cmd(CMD_ALLOC_RUN, 1, 0, 1, 1, STS_OK, 2);
		plan_cmd(CMD_ALLOC_RUN, 1024, 0, 1, 0, STS_EXHAUSTED, 2);
		plan_cmd(CMD_ALLOC_RUN, 1022, 0, 1, 2, STS_OK, 1024);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 0, STS_EXHAUSTED, 1024);
		// A run that walks past the last slot only frees the slot that exists.
		plan_cmd(CMD_FREE_RUN, 1024, 1023, 1, 0, STS_OK, 1023);
		// Double free is pushed and counted again.
		plan_cmd(CMD_FREE_RUN, 1, 1023, 1, 0, STS_OK, 1022);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 1023, STS_OK, 1023);
		// Fill the stack to the top; the last push is dropped and the live count bottoms out.
		plan_cmd(CMD_FREE_RUN, 1024, 0, 1, 0, STS_OVERFLOW, 0);
		plan_cmd(CMD_FREE_RUN, 3, 5, 1, 0, STS_OVERFLOW, 0);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 1022, STS_OK, 1);
		plan_cmd(CMD_CLEAR, 2047, 1023, 1, 0, STS_OK, 0);
		plan_cmd(CMD_ALLOC_ONE, 2047, 1023, 1, 0, STS_OK, 1);
		plan_cmd(CMD_ALLOC_RUN, 2, 0, 0, 0, STS_OK, 0);
		// A zero limit blocks the bump pointer but not the free stack.
		plan_cfg(0);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 0, STS_EXHAUSTED, 3);
		plan_cmd(CMD_ALLOC_RUN, 2, 0, 1, 0, STS_EXHAUSTED, 3);
		plan_cmd(CMD_FREE_RUN, 1, 0, 0, 0, STS_OK, 0);
		plan_cmd(CMD_FREE_RUN, 4, 700, 0, 0, STS_OK, 0);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 0, 0, STS_OK, 0);
		// A limit above the pool size acts as the pool size.
		plan_cfg(2047);
		plan_cmd(CMD_ALLOC_RUN, 1021, 0, 1, 3, STS_OK, 1024);
		plan_cmd(CMD_CLEAR, 0, 0, 1, 0, STS_OK, 0);
		plan_cfg(1);
		plan_cmd(CMD_ALLOC_RUN, 2, 0, 1, 0, STS_EXHAUSTED, 0);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 0, STS_OK, 1);
		plan_cmd(CMD_ALLOC_ONE, 0, 0, 1, 0, STS_EXHAUSTED, 1);

		// Reset sequence.
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_cfg)
				write_limit(plan[i].limit);
			else
				issue_cmd(plan[i].op, plan[i].n, plan[i].first, plan[i].typed, plan[i].want);
		end

		// Random phases: sender mostly busy, receiver mostly busy, then no idling but one long stall.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					write_limit(cnt_t'($urandom_range(1, 40)));
				end
				1: begin
					write_limit(cnt_t'($urandom_range(41, 2047)));
					send_idle_pct = 75;
					recv_idle_pct = 15;
				end
				default: begin
					write_limit(cnt_t'($urandom_range(0, 1024)));
					send_idle_pct = 0;
					recv_idle_pct = 0;
					hold_asked++;
				end
			endcase
			for (k = 0; k < PHASE_ITEMS; k++) begin
				issue_random_cmd();
				if (phase == 1 && k == PHASE_ITEMS / 2)
					drain_results();
			end
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
